/* src/qrs_pkg.sv */
// Shared widths, constants and helpers for the quadratic root solver.
package qrs_pkg;

  localparam int COEF_W  = 16;
  localparam int POLY_W  = 48;
  localparam int ROOT_W  = 32;
  localparam int DISC_W  = 35;                   // b*b - 4*a*c
  localparam int RAD_W   = 64;                   // |D| << 30
  localparam int SQRT_W  = 32;                   // floor(sqrt(RAD))
  localparam int NUM_W   = 34;                   // n0 +- s
  localparam int QUO_W   = NUM_W;                // quotient before saturation
  localparam int DIV_STEPS = NUM_W;

  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;

  localparam logic [1:0] CNT_COMPLEX = 2'd0;
  localparam logic [1:0] CNT_DOUBLE  = 2'd1;
  localparam logic [1:0] CNT_TWO     = 2'd2;

  // Saturate a signed quotient to Q16.16.
  function automatic logic signed [ROOT_W-1:0] sat32(input logic signed [QUO_W:0] v);
    logic signed [QUO_W:0] hi;
    logic signed [QUO_W:0] lo;
    hi = (QUO_W+1)'(64'sd2147483647);
    lo = -(QUO_W+1)'(64'sd2147483648);
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[ROOT_W-1:0];
  endfunction

endpackage

/* src/qrs_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [qrs_pkg::RAD_W-1:0]   rad,
  output logic                        out_valid,
  output logic [qrs_pkg::SQRT_W-1:0]  root
);
  localparam int N = qrs_pkg::SQRT_W;

  logic                           vld [N+1];
  logic [qrs_pkg::RAD_W-1:0]      rem [N+1];
  logic [qrs_pkg::RAD_W-1:0]      val [N+1];
  logic [N-1:0]                   res [N+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign val[0] = rad;
  assign res[0] = '0;

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [qrs_pkg::RAD_W+1:0] trial;
    logic [qrs_pkg::RAD_W+1:0] cur;
    always_comb begin
      cur   = {rem[i], val[i][qrs_pkg::RAD_W-1 -: 2]};
      trial = {{(qrs_pkg::RAD_W+2-N-2){1'b0}}, res[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      val[i+1] <= {val[i][qrs_pkg::RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem[i+1] <= qrs_pkg::RAD_W'(cur - trial);
        res[i+1] <= {res[i][N-2:0], 1'b1};
      end else begin
        rem[i+1] <= qrs_pkg::RAD_W'(cur);
        res[i+1] <= {res[i][N-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N];
endmodule

/* src/qrs_div.sv */
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
module qrs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [qrs_pkg::NUM_W-1:0]  num,
  input  logic signed [qrs_pkg::COEF_W-1:0] den,
  output logic                              out_valid,
  output logic signed [qrs_pkg::QUO_W:0]    quo
);
  localparam int N = qrs_pkg::NUM_W;
  localparam int D = qrs_pkg::COEF_W;

  logic         vld [N+1];
  logic [N-1:0] nv  [N+1];
  logic [D:0]   dv  [N+1];
  logic [D:0]   rm  [N+1];
  logic         neg [N+1];

  assign vld[0] = in_valid;
  assign nv[0]  = num[N-1] ? N'(-num) : N'(num);
  assign dv[0]  = den[D-1] ? (D+1)'(-$signed({den[D-1], den})) : {1'b0, den};
  assign rm[0]  = '0;
  assign neg[0] = num[N-1] ^ den[D-1];

  // Restoring division: shift in one numerator bit, subtract if it fits.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [D+1:0] cur;
    assign cur = {rm[i], nv[i][N-1]};
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      dv[i+1]  <= dv[i];
      neg[i+1] <= neg[i];
      if (cur >= {1'b0, dv[i]}) begin
        rm[i+1] <= (D+1)'(cur - {1'b0, dv[i]});
        nv[i+1] <= {nv[i][N-2:0], 1'b1};
      end else begin
        rm[i+1] <= (D+1)'(cur);
        nv[i+1] <= {nv[i][N-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[N];
  assign quo = neg[N] ? -$signed({1'b0, nv[N]}) : $signed({1'b0, nv[N]});
endmodule

/* src/quadratic_root_solver.sv */
// Top level of the quadratic evaluator and root solver.
//   channel  | handshake            | payload
//   config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   input    | start/busy           | x_point, other_a, other_b, other_c
//   result   | done strobe          | poly_value .. degenerate
// One item may enter every cycle; busy is held low.
// Items pass through the product stages, the square root pipe, the quotient
// pipe and the output register. Sync reset clears all valid bits.
// The receiver cannot stall; every result shows for one cycle on done.
module quadratic_root_solver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [qrs_pkg::COEF_W-1:0]        cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qrs_pkg::COEF_W-1:0] x_point,
  input  logic signed [qrs_pkg::COEF_W-1:0] other_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] other_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] other_c,
  output logic                              done,
  output logic signed [qrs_pkg::POLY_W-1:0] poly_value,
  output logic [1:0]                        real_root_count,
  output logic signed [qrs_pkg::ROOT_W-1:0] root0_real,
  output logic signed [qrs_pkg::ROOT_W-1:0] root0_imag,
  output logic signed [qrs_pkg::ROOT_W-1:0] root1_real,
  output logic signed [qrs_pkg::ROOT_W-1:0] root1_imag,
  output logic                              curves_meet,
  output logic                              degenerate
);
  localparam int LAT_SQ = qrs_pkg::SQRT_W;
  localparam int LAT_DV = qrs_pkg::DIV_STEPS;
  localparam int DLY    = LAT_SQ + LAT_DV;

  typedef struct packed {
    logic signed [qrs_pkg::POLY_W-1:0] poly;
    logic                              meet;
    logic                              degen;
    logic                              dneg;
    logic                              dzero;
    logic                              aneg;
  } side_t;

  logic signed [qrs_pkg::COEF_W-1:0] a, b, c;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a <= '0; b <= '0; c <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        qrs_pkg::REG_A: a <= cfg_data;
        qrs_pkg::REG_B: b <= cfg_data;
        qrs_pkg::REG_C: c <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: products
  logic v1;
  logic signed [31:0] ax1, bb1, ac1, bx1;
  logic signed [35:0] db1sq, dadc1;
  logic signed [15:0] x1;
  logic signed [qrs_pkg::COEF_W-1:0] a1, b1, c1;
  logic signed [16:0] da, db, dc;
  assign da = a - other_a;
  assign db = b - other_b;
  assign dc = c - other_c;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    ax1   <= a * x_point;
    bx1   <= b * x_point;
    bb1   <= b * b;
    ac1   <= a * c;
    db1sq <= 36'(db * db);
    dadc1 <= 36'(da * dc);
    x1 <= x_point; a1 <= a; b1 <= b; c1 <= c;
  end

  // Stage 2: second products and discriminants
  logic v2;
  logic signed [47:0] axx2, bx2;
  logic signed [qrs_pkg::DISC_W-1:0] d2;
  logic meet2;
  logic signed [qrs_pkg::COEF_W-1:0] a2, b2, c2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    axx2  <= 48'(ax1 * x1);
    bx2   <= 48'(bx1) <<< 8;
    d2    <= qrs_pkg::DISC_W'(bb1) - (qrs_pkg::DISC_W'(ac1) <<< 2);
    meet2 <= (db1sq - (dadc1 <<< 2)) >= 0;
    a2 <= a1; b2 <= b1; c2 <= c1;
  end

  // Stage 3: sum polynomial, form sqrt operand
  logic v3;
  side_t s3;
  logic [qrs_pkg::RAD_W-1:0] rad3;
  logic signed [qrs_pkg::COEF_W-1:0] a3, b3;
  logic [qrs_pkg::DISC_W-1:0] mag2;
  assign mag2 = d2[qrs_pkg::DISC_W-1] ? qrs_pkg::DISC_W'(-d2) : qrs_pkg::DISC_W'(d2);
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    s3.poly  <= axx2 + bx2 + (48'(c2) <<< 16);
    s3.meet  <= meet2;
    s3.degen <= (a2 == '0);
    s3.dneg  <= d2[qrs_pkg::DISC_W-1];
    s3.dzero <= (d2 == '0);
    s3.aneg  <= a2[qrs_pkg::COEF_W-1];
    rad3 <= qrs_pkg::RAD_W'(mag2) << 30;
    a3 <= a2; b3 <= b2;
  end

  // Square root pipe, with side data delayed alongside
  logic vs;
  logic [qrs_pkg::SQRT_W-1:0] sq;
  qrs_sqrt u_sqrt (.clk, .rst, .in_valid(v3), .rad(rad3), .out_valid(vs), .root(sq));

  side_t side_q [DLY+1];
  logic signed [qrs_pkg::COEF_W-1:0] a_q [LAT_SQ+1];
  logic signed [qrs_pkg::COEF_W-1:0] b_q [LAT_SQ+1];
  assign side_q[0] = s3;
  assign a_q[0] = a3;
  assign b_q[0] = b3;
  for (genvar i = 0; i < DLY; i++) begin : g_side
    always_ff @(posedge clk) side_q[i+1] <= side_q[i];
  end
  for (genvar i = 0; i < LAT_SQ; i++) begin : g_ab
    always_ff @(posedge clk) begin
      a_q[i+1] <= a_q[i];
      b_q[i+1] <= b_q[i];
    end
  end

  // Numerators: real roots use n0-s and n0+s; complex pair uses n0 and s.
  // Both are divided by a; the imaginary magnitude takes the sign of a off.
  logic signed [qrs_pkg::NUM_W-1:0] n0, nlo, nhi, num0, num1;
  logic cplx;
  assign cplx = side_q[LAT_SQ].dneg;
  assign n0   = -(qrs_pkg::NUM_W'(b_q[LAT_SQ]) <<< 15);
  assign nlo  = n0 - qrs_pkg::NUM_W'({1'b0, sq});
  assign nhi  = n0 + qrs_pkg::NUM_W'({1'b0, sq});
  assign num0 = cplx ? n0 : nlo;
  assign num1 = cplx ? qrs_pkg::NUM_W'({1'b0, sq}) : nhi;

  logic vd, vd1;
  logic signed [qrs_pkg::QUO_W:0] q0, q1;
  qrs_div u_div0 (.clk, .rst, .in_valid(vs), .num(num0), .den(a_q[LAT_SQ]),
                  .out_valid(vd), .quo(q0));
  qrs_div u_div1 (.clk, .rst, .in_valid(vs), .num(num1), .den(a_q[LAT_SQ]),
                  .out_valid(vd1), .quo(q1));

  // Output stage: order, saturate, degenerate override
  side_t so;
  logic signed [qrs_pkg::QUO_W:0] lo, hi;
  assign so = side_q[DLY];
  assign lo = (q0 < q1) ? q0 : q1;
  assign hi = (q0 < q1) ? q1 : q0;
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vd;
    poly_value  <= so.poly;
    curves_meet <= so.meet;
    degenerate  <= so.degen;
    if (so.degen) begin
      real_root_count <= qrs_pkg::CNT_COMPLEX;
      root0_real <= '0; root0_imag <= '0; root1_real <= '0; root1_imag <= '0;
    end else if (so.dneg) begin
      real_root_count <= qrs_pkg::CNT_COMPLEX;
      root0_real <= qrs_pkg::sat32(q0);
      root1_real <= qrs_pkg::sat32(q0);
      root0_imag <= qrs_pkg::sat32(so.aneg ? q1 : -q1);
      root1_imag <= qrs_pkg::sat32(so.aneg ? -q1 : q1);
    end else begin
      real_root_count <= so.dzero ? qrs_pkg::CNT_DOUBLE : qrs_pkg::CNT_TWO;
      root0_real <= qrs_pkg::sat32(lo);
      root1_real <= qrs_pkg::sat32(hi);
      root0_imag <= '0; root1_imag <= '0;
    end
  end

  // Checks
  a_div_sync: assert property (@(posedge clk) disable iff (rst) vd == vd1)
    else $error("divider pipes out of step");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> root0_real == 0 && root1_real == 0 && real_root_count == 0)
    else $error("degenerate result carries roots");
  a_order: assert property (@(posedge clk) disable iff (rst)
    done && real_root_count != qrs_pkg::CNT_COMPLEX |-> root0_real <= root1_real)
    else $error("real roots out of order");
endmodule
